>>> rtl/als_pkg.sv
// shared types and constants for the adjacency list store
// vertex, degree and address widths, command and status codes, sequencer states
// no dependencies
package als_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int MAX_DEGREE   = 16;

    localparam int VERT_W = $clog2(MAX_VERTICES);
    localparam int NV_W   = VERT_W + 1;
    localparam int SLOT_W = $clog2(MAX_DEGREE);
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int ADDR_W = VERT_W + SLOT_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_LIST   = 2'd2,
        CMD_DEGREE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DA,
        S_DB,
        S_WB,
        S_SELF2,
        S_SCAN,
        S_LIST,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VERT_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } adj_req_t;

    typedef struct packed {
        logic              we;
        logic [VERT_W-1:0] waddr;
        logic [DEG_W-1:0]  wdata;
        logic [VERT_W-1:0] raddr;
    } deg_req_t;

endpackage

>>> rtl/als_deg_mem.sv
// degree table: one write and one registered read per cycle
// per-entry valid bits cleared at reset make unwritten entries read as zero
// depends on als_pkg
module als_deg_mem (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  als_pkg::deg_req_t        req,
    output logic [als_pkg::DEG_W-1:0] rdata
);

    logic [als_pkg::DEG_W-1:0] mem [als_pkg::MAX_VERTICES];
    logic [als_pkg::MAX_VERTICES-1:0] vld_reg;
    logic [als_pkg::DEG_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= vld_reg[req.raddr] ? mem[req.raddr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.we) begin
            vld_reg[req.waddr] <= 1'b1;
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/als_adj_mem.sv
// neighbour list store, slot vertex*MAX_DEGREE+i
// one write and one registered read per cycle, contents undefined until written
// depends on als_pkg
module als_adj_mem (
    input  logic                      aclk,
    input  als_pkg::adj_req_t         req,
    output logic [als_pkg::VERT_W-1:0] rdata
);

    logic [als_pkg::VERT_W-1:0] mem [als_pkg::MAX_VERTICES * als_pkg::MAX_DEGREE];
    logic [als_pkg::VERT_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/als_seq.sv
// command sequencer: range check, degree lookups, list walk with one compare per cycle
// drives both memories and holds the result beat register
// depends on als_pkg
module als_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [als_pkg::NV_W-1:0]   num_vertices,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  als_pkg::cmd_t              s_command,
    input  logic [als_pkg::VERT_W-1:0] s_vertex_a,
    input  logic [als_pkg::VERT_W-1:0] s_vertex_b,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output als_pkg::status_t           m_status,
    output logic                       m_found,
    output logic [als_pkg::DEG_W-1:0]  m_degree,
    output logic [als_pkg::VERT_W-1:0] m_neighbour,
    output logic                       m_last,
    output als_pkg::deg_req_t          deg_req,
    input  logic [als_pkg::DEG_W-1:0]  deg_rdata,
    output als_pkg::adj_req_t          adj_req,
    input  logic [als_pkg::VERT_W-1:0] adj_rdata
);

    als_pkg::state_t state_reg, state_next;
    als_pkg::cmd_t   cmd_reg, cmd_next;
    logic [als_pkg::VERT_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [als_pkg::DEG_W-1:0]  da_reg, da_next, db_reg, db_next, idx_reg, idx_next;

    als_pkg::status_t out_status_reg, out_status_next;
    logic out_found_reg, out_found_next, out_last_reg, out_last_next;
    logic [als_pkg::DEG_W-1:0]  out_deg_reg, out_deg_next;
    logic [als_pkg::VERT_W-1:0] out_nb_reg, out_nb_next;

    logic [als_pkg::NV_W-1:0]  lim;
    logic                      a_ok, b_ok, need_b;
    logic [als_pkg::DEG_W-1:0] da_inc, da_inc2, db_inc, idx_inc;

    assign lim = (num_vertices > als_pkg::NV_W'(als_pkg::MAX_VERTICES)) ?
                 als_pkg::NV_W'(als_pkg::MAX_VERTICES) : num_vertices;
    assign a_ok    = {1'b0, s_vertex_a} < lim;
    assign b_ok    = {1'b0, s_vertex_b} < lim;
    assign need_b  = (s_command == als_pkg::CMD_INSERT) || (s_command == als_pkg::CMD_QUERY);
    assign da_inc  = da_reg + als_pkg::DEG_W'(1);
    assign da_inc2 = da_reg + als_pkg::DEG_W'(2);
    assign db_inc  = db_reg + als_pkg::DEG_W'(1);
    assign idx_inc = idx_reg + als_pkg::DEG_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= als_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        da_reg         <= da_next;
        db_reg         <= db_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_deg_reg    <= out_deg_next;
        out_nb_reg     <= out_nb_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        da_next         = da_reg;
        db_next         = db_reg;
        idx_next        = idx_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_deg_next    = out_deg_reg;
        out_nb_next     = out_nb_reg;
        out_last_next   = out_last_reg;
        deg_req         = '0;
        deg_req.raddr   = a_reg;
        adj_req         = '0;

        unique case (state_reg)
            als_pkg::S_IDLE: begin
                deg_req.raddr = s_vertex_a;
                if (s_tvalid) begin
                    cmd_next = s_command;
                    a_next   = s_vertex_a;
                    b_next   = s_vertex_b;
                    if (!a_ok || (need_b && !b_ok)) begin
                        out_status_next = als_pkg::ST_RANGE;
                        out_found_next  = 1'b0;
                        out_deg_next    = '0;
                        out_nb_next     = '0;
                        out_last_next   = 1'b1;
                        state_next      = als_pkg::S_OUT;
                    end else begin
                        state_next = als_pkg::S_DA;
                    end
                end
            end
            als_pkg::S_DA: begin
                da_next         = deg_rdata;
                idx_next        = '0;
                deg_req.raddr   = b_reg;
                out_status_next = als_pkg::ST_OK;
                out_found_next  = 1'b0;
                out_deg_next    = deg_rdata;
                out_nb_next     = '0;
                out_last_next   = 1'b1;
                state_next      = als_pkg::S_OUT;
                unique case (cmd_reg)
                    als_pkg::CMD_INSERT: begin
                        if (a_reg == b_reg) begin
                            if (deg_rdata > als_pkg::DEG_W'(als_pkg::MAX_DEGREE - 2)) begin
                                out_status_next = als_pkg::ST_FULL;
                            end else begin
                                adj_req.we    = 1'b1;
                                adj_req.waddr = {a_reg, deg_rdata[als_pkg::SLOT_W-1:0]};
                                adj_req.wdata = a_reg;
                                deg_req.we    = 1'b1;
                                deg_req.waddr = a_reg;
                                deg_req.wdata = deg_rdata + als_pkg::DEG_W'(2);
                                state_next    = als_pkg::S_SELF2;
                            end
                        end else begin
                            state_next = als_pkg::S_DB;
                        end
                    end
                    als_pkg::CMD_QUERY: begin
                        if (deg_rdata != '0) begin
                            state_next = als_pkg::S_SCAN;
                        end
                    end
                    als_pkg::CMD_LIST: begin
                        if (deg_rdata != '0) begin
                            state_next = als_pkg::S_LIST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            als_pkg::S_SELF2: begin
                adj_req.we      = 1'b1;
                adj_req.waddr   = {a_reg, da_inc[als_pkg::SLOT_W-1:0]};
                adj_req.wdata   = a_reg;
                out_status_next = als_pkg::ST_OK;
                out_deg_next    = da_inc2;
                state_next      = als_pkg::S_OUT;
            end
            als_pkg::S_DB: begin
                db_next    = deg_rdata;
                state_next = als_pkg::S_OUT;
                if (da_reg >= als_pkg::DEG_W'(als_pkg::MAX_DEGREE) ||
                    deg_rdata >= als_pkg::DEG_W'(als_pkg::MAX_DEGREE)) begin
                    out_status_next = als_pkg::ST_FULL;
                end else begin
                    adj_req.we    = 1'b1;
                    adj_req.waddr = {a_reg, da_reg[als_pkg::SLOT_W-1:0]};
                    adj_req.wdata = b_reg;
                    deg_req.we    = 1'b1;
                    deg_req.waddr = a_reg;
                    deg_req.wdata = da_inc;
                    state_next    = als_pkg::S_WB;
                end
            end
            als_pkg::S_WB: begin
                adj_req.we    = 1'b1;
                adj_req.waddr = {b_reg, db_reg[als_pkg::SLOT_W-1:0]};
                adj_req.wdata = a_reg;
                deg_req.we    = 1'b1;
                deg_req.waddr = b_reg;
                deg_req.wdata = db_inc;
                out_deg_next  = da_inc;
                state_next    = als_pkg::S_OUT;
            end
            als_pkg::S_SCAN: begin
                if (adj_rdata == b_reg) begin
                    out_found_next = 1'b1;
                    state_next     = als_pkg::S_OUT;
                end else if (idx_inc == da_reg) begin
                    state_next = als_pkg::S_OUT;
                end else begin
                    idx_next = idx_inc;
                end
            end
            als_pkg::S_LIST: begin
                out_nb_next   = adj_rdata;
                out_last_next = (idx_inc == da_reg);
                state_next    = als_pkg::S_OUT;
            end
            als_pkg::S_OUT: begin
                if (m_tready) begin
                    if (out_last_reg) begin
                        state_next = als_pkg::S_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = als_pkg::S_LIST;
                    end
                end
            end
            default: begin
                state_next = als_pkg::S_IDLE;
            end
        endcase

        adj_req.raddr = {a_reg, idx_next[als_pkg::SLOT_W-1:0]};
    end

    assign s_tready    = (state_reg == als_pkg::S_IDLE);
    assign m_tvalid    = (state_reg == als_pkg::S_OUT);
    assign m_status    = out_status_reg;
    assign m_found     = out_found_reg;
    assign m_degree    = out_deg_reg;
    assign m_neighbour = out_nb_reg;
    assign m_last      = out_last_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result beat is pending");

    a_range_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_status == als_pkg::ST_RANGE) |->
        (!m_found && m_degree == '0 && m_neighbour == '0 && m_last))
        else $error("range error beat carries data");

    a_deg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        deg_req.we |-> (deg_req.wdata <= als_pkg::DEG_W'(als_pkg::MAX_DEGREE)))
        else $error("degree written past list capacity");

    a_found_query: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_found) |-> (cmd_reg == als_pkg::CMD_QUERY))
        else $error("found flag outside adjacency query");

    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        adj_req.we |-> (cmd_reg == als_pkg::CMD_INSERT && !m_tvalid))
        else $error("list store written outside insert");

endmodule

>>> rtl/adjacency_list_store_core.sv
// Undirected graph store with bounded per-vertex neighbour lists. Commands arrive one beat
// at a time and the block is not ready until the last result beat of the current command
// has been taken. An adjacency query walks the list store one slot per cycle; a listing
// returns one neighbour per result beat and holds while the output stalls. Degree counters
// clear at reset with no clearing pass; no dead time.
// depends on als_pkg, als_seq, als_deg_mem, als_adj_mem
module adjacency_list_store_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], vertex_a[9:2], vertex_b[17:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], found[2], degree_value[7:3], neighbour[15:8]
    output logic        m_tlast
);

    logic [als_pkg::NV_W-1:0]   num_vertices_reg;
    als_pkg::deg_req_t          deg_req;
    als_pkg::adj_req_t          adj_req;
    logic [als_pkg::DEG_W-1:0]  deg_rdata;
    logic [als_pkg::VERT_W-1:0] adj_rdata;
    als_pkg::status_t           m_status;
    logic                       m_found;
    logic [als_pkg::DEG_W-1:0]  m_degree;
    logic [als_pkg::VERT_W-1:0] m_neighbour;
    logic                       cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr == 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_vertices_reg <= als_pkg::NV_W'(als_pkg::MAX_VERTICES);
        end else if (psel && penable && pwrite && cfg_sel) begin
            num_vertices_reg <= pwdata[als_pkg::NV_W-1:0];
        end
    end

    assign prdata = cfg_sel ? {{(32-als_pkg::NV_W){1'b0}}, num_vertices_reg} : 32'd0;

    als_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .num_vertices (num_vertices_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_command    (als_pkg::cmd_t'(s_tdata[1:0])),
        .s_vertex_a   (s_tdata[9:2]),
        .s_vertex_b   (s_tdata[17:10]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_degree     (m_degree),
        .m_neighbour  (m_neighbour),
        .m_last       (m_tlast),
        .deg_req      (deg_req),
        .deg_rdata    (deg_rdata),
        .adj_req      (adj_req),
        .adj_rdata    (adj_rdata)
    );

    als_deg_mem u_deg_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (deg_req),
        .rdata   (deg_rdata)
    );

    als_adj_mem u_adj_mem (
        .aclk  (aclk),
        .req   (adj_req),
        .rdata (adj_rdata)
    );

    assign m_tdata = {m_neighbour, m_degree, m_found, m_status};

endmodule
